/* rtl/bba_pkg.sv */
// shared constants, types and score/size functions for the buddy block allocator
package bba_pkg;

    localparam int INDEX_BITS      = 16;
    localparam int BLOCK_BYTES     = 12;
    localparam int MAX_ALLOC_BYTES = 786432;
    localparam int BLOCK_COUNT     = 1 << INDEX_BITS;
    localparam int TOP_ORDER       = INDEX_BITS;
    localparam int LOOP_LIMIT      = 2 * INDEX_BITS + 4;
    localparam int BYTES_W         = 20;
    localparam int COUNT_W         = 16;
    localparam int ORDER_W         = $clog2(TOP_ORDER + 2);
    localparam int STEP_W          = $clog2(LOOP_LIMIT + 1);
    localparam int SCORE_W         = INDEX_BITS + 2;
    localparam int TZ_W            = $clog2(INDEX_BITS + 1);

    typedef logic [INDEX_BITS-1:0] t_index;
    typedef logic [ORDER_W-1:0]    t_order;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [BYTES_W-1:0]    t_bytes;
    typedef logic [STEP_W-1:0]     t_step;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FREE   = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    // one link memory word: left and right child
    typedef struct packed {
        t_index left;
        t_index right;
    } t_link;

    typedef struct packed {
        logic [1:0] we;     // [1] right half, [0] left half
        t_index     addr;
        t_link      data;
    } t_link_wr;

    // smallest order whose region holds the byte count, TOP_ORDER + 1 when too large
    function automatic t_order size_order(input t_bytes bytes);
        t_order o;
        o = ORDER_W'(TOP_ORDER + 1);
        if (32'(bytes) < 32'(MAX_ALLOC_BYTES)) begin
            for (int w = TOP_ORDER; w >= 0; w--) begin
                if (32'(bytes) <= (32'(BLOCK_BYTES) << w)) begin
                    o = ORDER_W'(w);
                end
            end
        end
        return o;
    endfunction

    // heap key of a free region: 2^tz + (count - idx) - pop
    function automatic logic [SCORE_W-1:0] score(input t_index idx);
        logic [INDEX_BITS:0] full;
        t_index              d;
        logic [TZ_W-1:0]     tz;
        logic [TZ_W-1:0]     pop;
        full = (INDEX_BITS+1)'(BLOCK_COUNT) - {1'b0, idx};
        d    = full[INDEX_BITS-1:0];
        tz   = TZ_W'(INDEX_BITS);
        pop  = '0;
        for (int i = INDEX_BITS - 1; i >= 0; i--) begin
            if (d[i]) begin
                tz = TZ_W'(i);
            end
        end
        for (int i = 0; i < INDEX_BITS; i++) begin
            pop = pop + TZ_W'(d[i]);
        end
        return (SCORE_W'(1) << tz) + SCORE_W'(full) - SCORE_W'(pop);
    endfunction

endpackage

/* rtl/bba_link_mem.sv */
// child link memory with separate write and read ports, per-half write lanes and registered read
module bba_link_mem (
    input  logic              i_clk,
    input  bba_pkg::t_link_wr i_wr,
    input  logic              i_rd_en,
    input  bba_pkg::t_index   i_rd_addr,
    output bba_pkg::t_link    o_rd_data
);
    import bba_pkg::*;

    t_index r_mem_left  [0:BLOCK_COUNT-1];
    t_index r_mem_right [0:BLOCK_COUNT-1];
    t_link  r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we[0]) begin
            r_mem_left[i_wr.addr] <= i_wr.data.left;
        end
        if (i_wr.we[1]) begin
            r_mem_right[i_wr.addr] <= i_wr.data.right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data.left  <= r_mem_left[i_rd_addr];
            r_rd_data.right <= r_mem_right[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/bba_score_cmp.sv */
// shared heap key comparator: is score(a) below score(b)
module bba_score_cmp (
    input  bba_pkg::t_index i_a,
    input  bba_pkg::t_index i_b,
    output logic            o_a_lt_b
);
    import bba_pkg::*;

    logic [SCORE_W-1:0] score_a;
    logic [SCORE_W-1:0] score_b;

    assign score_a  = score(i_a);
    assign score_b  = score(i_b);
    assign o_a_lt_b = (score_a < score_b);

endmodule

/* rtl/buddy_block_allocator.sv */
// buddy block allocator top level: trie walk sequencer, order roots and counters
// latency: a size error or a zero-index free goes from the decode state straight to its result;
//   other items walk the trie level by level in the remove, insert descent and sift and
//   displace walks, each walk capped at 36 steps
// throughput: one item in flight; busy stays high from the accepted word to its result strobe
// reset: a clearing pass writes every link word to zero, with busy high
// the result is shown for one cycle on o_valid and cannot be stalled
module buddy_block_allocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_cmd,
    input  logic [19:0]          i_req_bytes,
    input  logic [15:0]          i_block_index,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [15:0]          o_alloc_index,
    output logic [15:0]          o_used_blocks,
    output logic [15:0]          o_live_allocs
);
    import bba_pkg::*;

    typedef enum logic [21:0] {
        S_CLEAR     = 22'b1 << 0,
        S_IDLE      = 22'b1 << 1,
        S_DECODE    = 22'b1 << 2,
        S_A_SCAN    = 22'b1 << 3,
        S_A_HGET    = 22'b1 << 4,
        S_A_SPLIT   = 22'b1 << 5,
        S_F_LOOP    = 22'b1 << 6,
        S_F_NEXT    = 22'b1 << 7,
        S_SO_STEP   = 22'b1 << 8,
        S_SO_RD     = 22'b1 << 9,
        S_SO_WB     = 22'b1 << 10,
        S_IN_START  = 22'b1 << 11,
        S_IN_CMP    = 22'b1 << 12,
        S_IN_GET    = 22'b1 << 13,
        S_IN_SW     = 22'b1 << 14,
        S_IN_SW_RD  = 22'b1 << 15,
        S_IN_SW_CP  = 22'b1 << 16,
        S_IN_FIN    = 22'b1 << 17,
        S_IN_ZERO   = 22'b1 << 18,
        S_RM_GET    = 22'b1 << 19,
        S_RM_LGET   = 22'b1 << 20,
        S_DONE      = 22'b1 << 21
    } t_state;

    t_state              r_state, n_state;
    t_index              r_clr, n_clr;
    t_cmd                r_cmd, n_cmd;
    t_order              r_order, n_order;
    t_order              r_k, n_k;
    t_index              r_fidx, n_fidx;
    t_index              r_node, n_node;
    t_index              r_cur, n_cur;
    t_index              r_l, n_l;
    t_index              r_r, n_r;
    t_index              r_next, n_next;
    logic                r_nside, n_nside;
    logic                r_ref_root, n_ref_root;
    t_index              r_ref_node, n_ref_node;
    logic                r_ref_side, n_ref_side;
    t_index              r_centre, n_centre;
    logic [INDEX_BITS:0] r_span, n_span;
    t_step               r_step, n_step;
    t_status             r_status, n_status;
    t_index              r_result, n_result;
    t_count              r_blocks, n_blocks;
    t_count              r_allocs, n_allocs;
    t_index              r_roots [0:TOP_ORDER];

    logic                root_we;
    t_index              root_wdata;
    t_index              root_rd;
    t_link_wr            mem_wr;
    logic                mem_rd_en;
    t_index              mem_rd_addr;
    t_link               mem_rd;
    t_index              cmp_a, cmp_b;
    logic                cmp_lt;
    logic                set_en;
    t_index              set_val;
    t_index              span_half;
    t_index              cen_dn, cen_up;
    t_index              ref_cur;
    t_index              step_bit;
    t_count              order_blocks;
    t_step               step_inc;
    t_state              so_ret, in_ret;

    bba_link_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd)
    );

    bba_score_cmp u_cmp (
        .i_a      (cmp_a),
        .i_b      (cmp_b),
        .o_a_lt_b (cmp_lt)
    );

    assign root_rd      = (r_k <= ORDER_W'(TOP_ORDER)) ? r_roots[r_k] : '0;
    assign span_half    = r_span[INDEX_BITS:1];
    assign cen_dn       = r_centre - span_half;
    assign cen_up       = r_centre + span_half;
    assign ref_cur      = r_ref_side ? mem_rd.right : mem_rd.left;
    assign step_bit     = t_index'(1) << r_k;
    assign order_blocks = COUNT_W'((TOP_ORDER+1)'(1) << r_order);
    assign step_inc     = r_step + t_step'(1);
    assign so_ret       = (r_cmd == CMD_FREE) ? S_F_NEXT : S_A_SPLIT;
    assign in_ret       = (r_cmd == CMD_FREE) ? S_DONE : S_A_SPLIT;

    // the comparator is shared by the sift choice and the insert walk
    assign cmp_a = (r_state == S_IN_CMP) ? r_cur  : r_l;
    assign cmp_b = (r_state == S_IN_CMP) ? r_node : r_r;

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cmd      = r_cmd;
        n_order    = r_order;
        n_k        = r_k;
        n_fidx     = r_fidx;
        n_node     = r_node;
        n_cur      = r_cur;
        n_l        = r_l;
        n_r        = r_r;
        n_next     = r_next;
        n_nside    = r_nside;
        n_ref_root = r_ref_root;
        n_ref_node = r_ref_node;
        n_ref_side = r_ref_side;
        n_centre   = r_centre;
        n_span     = r_span;
        n_step     = r_step;
        n_status   = r_status;
        n_result   = r_result;
        n_blocks   = r_blocks;
        n_allocs   = r_allocs;
        root_we    = 1'b0;
        root_wdata = '0;
        mem_wr     = '0;
        mem_rd_en  = 1'b0;
        mem_rd_addr = r_cur;
        set_en     = 1'b0;
        set_val    = '0;

        case (r_state)
            S_CLEAR: begin
                mem_wr.we   = 2'b11;
                mem_wr.addr = r_clr;
                n_clr       = r_clr + t_index'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_cmd    = t_cmd'(i_cmd);
                    n_order  = size_order(i_req_bytes);
                    n_fidx   = i_block_index;
                    n_status = ST_OK;
                    n_result = '0;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_k = r_order;
                if (r_order > ORDER_W'(TOP_ORDER)) begin
                    n_status = ST_TOO_LARGE;
                    n_state  = S_DONE;
                end else if (r_cmd == CMD_ALLOC) begin
                    n_state = S_A_SCAN;
                end else if (r_fidx == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_allocs = r_allocs - t_count'(1);
                    n_blocks = r_blocks - order_blocks;
                    n_state  = S_F_LOOP;
                end
            end
            S_A_SCAN: begin
                if (r_k > ORDER_W'(TOP_ORDER)) begin
                    n_status = ST_NO_FREE;
                    n_state  = S_DONE;
                end else if (root_rd != '0) begin
                    n_fidx      = root_rd;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = root_rd;
                    n_state     = S_A_HGET;
                end else begin
                    n_k = r_k + t_order'(1);
                end
            end
            S_A_HGET: begin
                n_l        = mem_rd.left;
                n_r        = mem_rd.right;
                n_ref_root = 1'b1;
                n_step     = '0;
                n_state    = S_SO_STEP;
            end
            S_A_SPLIT: begin
                if (r_k == r_order) begin
                    n_result = r_fidx;
                    n_allocs = r_allocs + t_count'(1);
                    n_blocks = r_blocks + order_blocks;
                    n_state  = S_DONE;
                end else begin
                    // upper half of the split region goes to the order below
                    n_k     = r_k - t_order'(1);
                    n_node  = r_fidx + (t_index'(1) << (r_k - t_order'(1)));
                    n_state = S_IN_START;
                end
            end
            S_F_LOOP: begin
                if (r_k == ORDER_W'(TOP_ORDER)) begin
                    n_node  = r_fidx;
                    n_state = S_IN_START;
                end else begin
                    n_node     = r_fidx ^ step_bit;
                    n_ref_root = 1'b1;
                    n_centre   = '0;
                    n_span     = (INDEX_BITS+1)'(BLOCK_COUNT);
                    n_step     = '0;
                    n_state    = S_RM_GET;
                end
            end
            S_F_NEXT: begin
                n_fidx  = r_fidx & ~step_bit;
                n_k     = r_k + t_order'(1);
                n_state = S_F_LOOP;
            end
            S_SO_STEP: begin
                if (r_step >= t_step'(LOOP_LIMIT)) begin
                    n_state = so_ret;
                end else begin
                    if (r_l == '0) begin
                        n_next = r_r;
                        n_nside = 1'b1;
                    end else if (r_r == '0) begin
                        n_next = r_l;
                        n_nside = 1'b0;
                    end else if (cmp_lt) begin
                        n_next = r_r;
                        n_nside = 1'b1;
                    end else begin
                        n_next = r_l;
                        n_nside = 1'b0;
                    end
                    set_en  = 1'b1;
                    set_val = n_next;
                    n_state = (n_next == '0) ? so_ret : S_SO_RD;
                end
            end
            S_SO_RD: begin
                // read after the slot write, the slot may sit in the same word
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_next;
                n_ref_root  = 1'b0;
                n_ref_node  = r_next;
                n_ref_side  = r_nside;
                n_state     = S_SO_WB;
            end
            S_SO_WB: begin
                mem_wr.we         = 2'b11;
                mem_wr.addr       = r_next;
                mem_wr.data.left  = r_l;
                mem_wr.data.right = r_r;
                n_l     = mem_rd.left;
                n_r     = mem_rd.right;
                n_step  = step_inc;
                n_state = S_SO_STEP;
            end
            S_IN_START: begin
                if (r_node == '0) begin
                    n_state = in_ret;
                end else begin
                    n_ref_root = 1'b1;
                    n_cur      = root_rd;
                    n_centre   = '0;
                    n_span     = (INDEX_BITS+1)'(BLOCK_COUNT);
                    n_step     = '0;
                    n_state    = (root_rd == '0) ? S_IN_FIN : S_IN_CMP;
                end
            end
            S_IN_CMP: begin
                if (r_step >= t_step'(LOOP_LIMIT) || r_cur == '0) begin
                    n_state = S_IN_FIN;
                end else if (cmp_lt) begin
                    n_step  = '0;
                    n_state = S_IN_SW;
                end else begin
                    n_span     = r_span >> 1;
                    n_ref_root = 1'b0;
                    n_ref_node = r_cur;
                    if (r_node < r_centre) begin
                        n_ref_side = 1'b0;
                        n_centre   = cen_dn;
                    end else begin
                        n_ref_side = 1'b1;
                        n_centre   = cen_up;
                    end
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_cur;
                    n_state     = S_IN_GET;
                end
            end
            S_IN_GET: begin
                n_cur   = ref_cur;
                n_step  = step_inc;
                n_state = S_IN_CMP;
            end
            S_IN_SW: begin
                if (r_step >= t_step'(LOOP_LIMIT)) begin
                    n_state = in_ret;
                end else if (r_cur == '0) begin
                    n_state = S_IN_FIN;
                end else begin
                    set_en  = 1'b1;
                    set_val = r_node;
                    n_state = S_IN_SW_RD;
                end
            end
            S_IN_SW_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_cur;
                n_state     = S_IN_SW_CP;
            end
            S_IN_SW_CP: begin
                // new node takes the displaced node's children, then the displaced
                // node walks on below it
                mem_wr.we   = 2'b11;
                mem_wr.addr = r_node;
                mem_wr.data = mem_rd;
                n_span      = r_span >> 1;
                n_ref_root  = 1'b0;
                n_ref_node  = r_node;
                if (r_cur < r_centre) begin
                    n_ref_side = 1'b0;
                    n_centre   = cen_dn;
                    n_cur      = mem_rd.left;
                end else begin
                    n_ref_side = 1'b1;
                    n_centre   = cen_up;
                    n_cur      = mem_rd.right;
                end
                n_node  = r_cur;
                n_step  = step_inc;
                n_state = S_IN_SW;
            end
            S_IN_FIN: begin
                set_en  = 1'b1;
                set_val = r_node;
                n_state = S_IN_ZERO;
            end
            S_IN_ZERO: begin
                mem_wr.we   = 2'b11;
                mem_wr.addr = r_node;
                n_state     = in_ret;
            end
            S_RM_GET: begin
                n_cur = r_ref_root ? root_rd : ref_cur;
                if (n_cur == '0 || (n_cur != r_node && r_node == r_centre)) begin
                    // buddy not free: insert what has been merged so far
                    n_node  = r_fidx;
                    n_state = S_IN_START;
                end else if (n_cur == r_node) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_node;
                    n_state     = S_RM_LGET;
                end else begin
                    n_span     = r_span >> 1;
                    n_ref_root = 1'b0;
                    n_ref_node = n_cur;
                    if (r_node < r_centre) begin
                        n_ref_side = 1'b0;
                        n_centre   = cen_dn;
                    end else begin
                        n_ref_side = 1'b1;
                        n_centre   = cen_up;
                    end
                    n_step = step_inc;
                    if (step_inc >= t_step'(LOOP_LIMIT)) begin
                        n_node  = r_fidx;
                        n_state = S_IN_START;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = n_cur;
                        n_state     = S_RM_GET;
                    end
                end
            end
            S_RM_LGET: begin
                n_l     = mem_rd.left;
                n_r     = mem_rd.right;
                n_step  = '0;
                n_state = S_SO_STEP;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // slot write: a root register or one half of a link word
        if (set_en) begin
            if (r_ref_root) begin
                root_we    = 1'b1;
                root_wdata = set_val;
            end else begin
                mem_wr.we         = r_ref_side ? 2'b10 : 2'b01;
                mem_wr.addr       = r_ref_node;
                mem_wr.data.left  = set_val;
                mem_wr.data.right = set_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_blocks <= '0;
            r_allocs <= '0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_blocks <= n_blocks;
            r_allocs <= n_allocs;
            r_k      <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= TOP_ORDER; k++) begin
                r_roots[k] <= (k < TOP_ORDER) ? (t_index'(1) << k) : '0;
            end
        end else if (root_we) begin
            r_roots[r_k] <= root_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_order    <= n_order;
        r_fidx     <= n_fidx;
        r_node     <= n_node;
        r_cur      <= n_cur;
        r_l        <= n_l;
        r_r        <= n_r;
        r_next     <= n_next;
        r_nside    <= n_nside;
        r_ref_root <= n_ref_root;
        r_ref_node <= n_ref_node;
        r_ref_side <= n_ref_side;
        r_centre   <= n_centre;
        r_span     <= n_span;
        r_step     <= n_step;
        r_status   <= n_status;
        r_result   <= n_result;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_status      = r_status;
    assign o_alloc_index = r_result;
    assign o_used_blocks = r_blocks;
    assign o_live_allocs = r_allocs;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a busy period");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted word did not start work");

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("result strobe longer than one cycle");

    a_err_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_alloc_index == '0)
        else $error("error result carries a block index");

    a_err_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> $stable(o_used_blocks) && $stable(o_live_allocs))
        else $error("error result changed the counters");

endmodule

/* sim/tb_buddy_block_allocator.sv */
// self-checking testbench for the buddy block allocator
`timescale 1ns / 1ps

module tb_buddy_block_allocator;
    import bba_pkg::*;

    localparam int POOL      = 65536;
    localparam int ROOT_BASE = 2 * POOL;
    localparam int WALK_MAX  = 36;
    localparam int IDLE_MAX  = 300000;

    typedef struct {
        t_status     status;
        logic [15:0] index;
        logic [15:0] used;
        logic [15:0] live;
    } t_outcome;

    typedef struct {
        logic [15:0] index;
        logic [19:0] bytes;
    } t_region;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cmd = 1'b0;
    logic [19:0] i_req_bytes = '0;
    logic [15:0] i_block_index = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_alloc_index;
    logic [15:0] o_used_blocks;
    logic [15:0] o_live_allocs;

    // predictor state
    logic [15:0] kid_left [POOL];
    logic [15:0] kid_right[POOL];
    logic [15:0] free_root[17];
    logic [15:0] used_count;
    logic [15:0] live_count;

    t_outcome    pending[$];
    t_region     held[$];
    int          errors;
    int          words_sent;
    int          idle_cycles;
    bit          no_gaps;

    buddy_block_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_req_bytes   (i_req_bytes),
        .i_block_index (i_block_index),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_alloc_index (o_alloc_index),
        .o_used_blocks (o_used_blocks),
        .o_live_allocs (o_live_allocs)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned link_read(int unsigned r);
        if (r >= ROOT_BASE) begin
            return (r - ROOT_BASE <= 16) ? free_root[r - ROOT_BASE] : 0;
        end
        return r[0] ? kid_right[(r >> 1) & 16'hFFFF] : kid_left[(r >> 1) & 16'hFFFF];
    endfunction

    function automatic void link_write(int unsigned r, int unsigned v);
        if (r >= ROOT_BASE) begin
            if (r - ROOT_BASE <= 16) free_root[r - ROOT_BASE] = v[15:0];
        end else if (r[0]) begin
            kid_right[(r >> 1) & 16'hFFFF] = v[15:0];
        end else begin
            kid_left[(r >> 1) & 16'hFFFF] = v[15:0];
        end
    endfunction

    function automatic int unsigned heap_key(int unsigned idx);
        int unsigned full, d, tz, pop;
        full = POOL - (idx & 16'hFFFF);
        d    = full & 16'hFFFF;
        tz   = 0;
        pop  = $countones(d);
        if (d == 0) begin
            tz = 16;
        end else begin
            while (d[tz] == 1'b0) tz++;
        end
        return (1 << tz) + full - pop;
    endfunction

    // pull the better child up into the slot repeatedly
    function automatic void fill_hole(int unsigned r, int unsigned l, int unsigned rt);
        int unsigned nxt, ml, mr;
        for (int s = 0; s < WALK_MAX; s++) begin
            if (l == 0) begin
                nxt = rt;
                link_write(r, nxt);
                if (nxt == 0) return;
                r = nxt * 2 + 1;
            end else if (rt == 0 || heap_key(l) >= heap_key(rt)) begin
                nxt = l;
                link_write(r, nxt);
                r = nxt * 2;
            end else begin
                nxt = rt;
                link_write(r, nxt);
                r = nxt * 2 + 1;
            end
            ml = kid_left[nxt];
            mr = kid_right[nxt];
            kid_left[nxt]  = l[15:0];
            kid_right[nxt] = rt[15:0];
            l  = ml;
            rt = mr;
        end
    endfunction

    function automatic void add_free(int unsigned idx, int unsigned ord);
        int unsigned r, cur, k;
        int centre, span;
        r   = ROOT_BASE + ord;
        cur = link_read(r);
        idx = idx & 16'hFFFF;
        if (idx == 0) return;
        if (cur != 0) begin
            k = heap_key(idx);
            centre = 0;
            span = POOL;
            for (int s = 0; s < WALK_MAX && cur != 0; s++) begin
                if (heap_key(cur) < k) begin
                    // displace the weaker node downwards
                    for (int s2 = 0; s2 < WALK_MAX; s2++) begin
                        link_write(r, idx);
                        if (cur == 0) begin
                            kid_left[idx]  = '0;
                            kid_right[idx] = '0;
                            return;
                        end
                        kid_left[idx]  = kid_left[cur];
                        kid_right[idx] = kid_right[cur];
                        span = span >>> 1;
                        if (int'(cur) < centre) begin
                            r = idx * 2;
                            centre -= span;
                        end else begin
                            r = idx * 2 + 1;
                            centre += span;
                        end
                        idx = cur;
                        cur = link_read(r);
                    end
                    return;
                end
                span = span >>> 1;
                if (int'(idx) < centre) begin
                    r = cur * 2;
                    centre -= span;
                end else begin
                    r = cur * 2 + 1;
                    centre += span;
                end
                cur = link_read(r);
            end
        end
        link_write(r, idx);
        kid_left[idx]  = '0;
        kid_right[idx] = '0;
    endfunction

    function automatic bit take_free(int unsigned idx, int unsigned ord);
        int unsigned r, cur;
        int centre, span, s;
        r = ROOT_BASE + ord;
        centre = 0;
        span = POOL;
        idx = idx & 16'hFFFF;
        for (s = 0; ; s++) begin
            if (s >= WALK_MAX) return 1'b0;
            cur = link_read(r);
            if (cur == 0) return 1'b0;
            if (cur == idx) break;
            if (idx == (centre & 16'hFFFF)) return 1'b0;
            span = span >>> 1;
            if (int'(idx) < centre) begin
                r = cur * 2;
                centre -= span;
            end else begin
                r = cur * 2 + 1;
                centre += span;
            end
        end
        fill_hole(r, kid_left[idx], kid_right[idx]);
        return 1'b1;
    endfunction

    function automatic int unsigned bytes_to_order(int unsigned b);
        int unsigned blk, w;
        if (b >= MAX_ALLOC_BYTES) return 17;
        blk = (b + BLOCK_BYTES - 1) / BLOCK_BYTES;
        blk = (blk != 0) ? blk - 1 : 0;
        w = 0;
        while (blk != 0) begin
            w++;
            blk >>= 1;
        end
        return w;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < POOL; i++) begin
            kid_left[i]  = '0;
            kid_right[i] = '0;
        end
        for (int k = 0; k < 16; k++) free_root[k] = 16'(1 << k);
        free_root[16] = '0;
        used_count = '0;
        live_count = '0;
    endfunction

    function automatic t_outcome allocator_step(t_cmd c, int unsigned b, int unsigned bi);
        t_outcome    o;
        int unsigned ord, k, head, idx;
        ord = bytes_to_order(b);
        idx = bi & 16'hFFFF;
        o.status = ST_OK;
        o.index  = '0;
        if (ord > 16) begin
            o.status = ST_TOO_LARGE;
        end else if (c == CMD_ALLOC) begin
            k = ord;
            while (k <= 16 && free_root[k] == 0) k++;
            if (k > 16) begin
                o.status = ST_NO_FREE;
            end else begin
                head = free_root[k];
                fill_hole(ROOT_BASE + k, kid_left[head], kid_right[head]);
                while (k != ord) begin
                    k--;
                    add_free((head + (1 << k)) & 16'hFFFF, k);
                end
                o.index    = head[15:0];
                live_count = live_count + 16'd1;
                used_count = used_count + 16'(1 << ord);
            end
        end else if (idx != 0) begin
            k = ord;
            live_count = live_count - 16'd1;
            used_count = used_count - 16'(1 << ord);
            while (k != 16) begin
                if (!take_free((idx ^ (1 << k)) & 16'hFFFF, k)) break;
                idx = idx & ~(1 << k);
                k++;
            end
            add_free(idx, k);
        end
        o.used = used_count;
        o.live = live_count;
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // one command word; start stays high between back-to-back words
    task automatic send_word(t_cmd c, int unsigned b, int unsigned bi);
        int       gap;
        t_outcome o;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_cmd         <= c;
        i_req_bytes   <= b[19:0];
        i_block_index <= bi[15:0];
        do @(posedge i_clk); while (busy);
        o = allocator_step(c, b, bi);
        pending.push_back(o);
        words_sent++;
        if (c == CMD_ALLOC && o.status == ST_OK) begin
            held.push_back('{o.index, b[19:0]});
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic release_held(int n);
        t_region r;
        for (int i = 0; i < n && held.size() != 0; i++) begin
            r = held[0];
            held.pop_front();
            send_word(CMD_FREE, r.bytes, r.index);
        end
    endtask

    task automatic test_size_edges();
        send_word(CMD_ALLOC, 0, 16'hFFFF);
        send_word(CMD_ALLOC, 12, 0);
        send_word(CMD_ALLOC, 13, 0);
        send_word(CMD_ALLOC, 24, 0);
        send_word(CMD_ALLOC, 25, 0);
        send_word(CMD_ALLOC, MAX_ALLOC_BYTES, 0);
        send_word(CMD_ALLOC, 20'hFFFFF, 16'hFFFF);
        send_word(CMD_FREE, 20'hFFFFF, 16'h1234);
        send_word(CMD_ALLOC, MAX_ALLOC_BYTES - 1, 0);
        send_word(CMD_FREE, 12, 0);
    endtask

    task automatic test_exhaust();
        send_word(CMD_ALLOC, 12 * 32768, 0);
        send_word(CMD_ALLOC, 12 * 32768, 0);
        send_word(CMD_ALLOC, 12 * 16384, 0);
        send_word(CMD_ALLOC, 12 * 16384, 0);
        drain();
        release_held(held.size());
    endtask

    task automatic test_bad_frees();
        send_word(CMD_ALLOC, 48, 0);
        send_word(CMD_FREE, 48, held[held.size() - 1].index);
        send_word(CMD_FREE, 48, held[held.size() - 1].index);   // double free
        held.pop_back();
        send_word(CMD_FREE, 12, 16'h0003);                     // block not held
        send_word(CMD_FREE, 12 * 8, 16'h8000);                 // wrong size
    endtask

    task automatic test_random(int n);
        int unsigned pick, b;
        t_region     r;
        for (int i = 0; i < n; i++) begin
            if (i % 300 == 0) no_gaps = !no_gaps;
            if (i == n / 2) drain();
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_word(t_cmd'($urandom_range(0, 1)), $urandom_range(0, 20'hFFFFF),
                          $urandom_range(0, 16'hFFFF));
            end else if (held.size() != 0 && (pick < 48 || held.size() > 150)) begin
                b = $urandom_range(0, held.size() - 1);
                r = held[b];
                held.delete(b);
                send_word(CMD_FREE, r.bytes, r.index);
            end else begin
                b = (pick < 90) ? $urandom_range(0, 12 << $urandom_range(0, 5))
                                : $urandom_range(0, 12 << $urandom_range(6, 16));
                send_word(CMD_ALLOC, b, $urandom_range(0, 16'hFFFF));
            end
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && o_valid) begin
            if (pending.size() == 0) begin
                $display("result word with nothing expected");
                errors++;
            end else begin
                w = pending.pop_front();
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                if (o_alloc_index !== w.index) report_mismatch("index", o_alloc_index, w.index);
                if (o_used_blocks !== w.used) report_mismatch("used", o_used_blocks, w.used);
                if (o_live_allocs !== w.live) report_mismatch("live", o_live_allocs, w.live);
            end
        end
    end

    // watchdog, allows for the clearing pass after reset
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX) begin
            $display("FAIL buddy_block_allocator");
            $finish;
        end
    end

    initial begin
        errors = 0;
        words_sent = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        pool_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_size_edges();
        test_exhaust();
        test_bad_frees();
        test_random(1450);
        release_held(held.size());
        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d words: size edges, exhaustion, bad frees, random traffic",
                 words_sent);
        if (errors == 0) begin
            $display("PASS buddy_block_allocator");
        end else begin
            $display("FAIL buddy_block_allocator");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/bba_pkg.sv
rtl/bba_link_mem.sv
rtl/bba_score_cmp.sv
rtl/buddy_block_allocator.sv
sim/tb_buddy_block_allocator.sv
